// File: rtl/core/olpt_pkg.sv
// olpt_pkg: shared types and constants for the overcurrent level and peak tracker
// used by olpt_front, olpt_back and overcurrent_level_peak_tracker_top
// no dependencies
`default_nettype none

package olpt_pkg;

	// channel count and derived index width
	localparam int CHANNELS   = 8;
	localparam int CH_FIELD_W = 3;
	localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// field widths
	localparam int VAL_W  = 32;
	localparam int TIME_W = 63;
	localparam int WIN_W  = 16;
	localparam int CNT_W  = 32;
	localparam int MASK_W = 32;
	localparam int ID_W   = 5;
	localparam int BAND_W = 2;

	// configuration registers
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int THR_REGS   = 4;
	localparam int IDS_W      = 40;
	localparam int ID_SLOTS   = 8;

	localparam logic [CFG_IDX_W-1:0] REG_THR_CH01   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THR_CH23   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THR_CH45   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_THR_CH67   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MODULE_IDS = 3'd4;

	// band codes
	localparam logic [BAND_W-1:0] BAND_NONE = 2'd0;
	localparam logic [BAND_W-1:0] BAND_LOW  = 2'd1;
	localparam logic [BAND_W-1:0] BAND_MID  = 2'd2;
	localparam logic [BAND_W-1:0] BAND_HIGH = 2'd3;

	// queue geometry, shared by the classified queue and the result queue
	localparam int Q_DEPTH = 2;
	localparam int Q_AW    = 1;
	localparam int Q_CW    = 2;

	// input transaction
	typedef struct packed {
		logic [CH_FIELD_W-1:0] channel;
		logic [VAL_W-1:0]      sample_value;
		logic [TIME_W-1:0]     sample_time;
		logic [WIN_W-1:0]      window_index;
		logic                  new_window;
	} sample_t;

	// result transaction
	typedef struct packed {
		logic [CH_FIELD_W-1:0] out_channel;
		logic [BAND_W-1:0]     band;
		logic [MASK_W-1:0]     mitigation_mask;
		logic [CNT_W-1:0]      count_low;
		logic [CNT_W-1:0]      count_mid;
		logic [CNT_W-1:0]      count_high;
		logic [VAL_W-1:0]      peak_value;
		logic [TIME_W-1:0]     peak_time;
		logic [WIN_W-1:0]      peak_window;
		logic                  peak_updated;
	} result_t;

	// classified sample handed from front to back
	typedef struct packed {
		logic [CH_FIELD_W-1:0] channel;
		logic                  ch_ok;
		logic [BAND_W-1:0]     band;
		logic                  hit;
		logic [ID_W-1:0]       mit_id;
		logic                  new_window;
		logic [VAL_W-1:0]      sample_value;
		logic [TIME_W-1:0]     sample_time;
		logic [WIN_W-1:0]      window_index;
	} cls_t;

endpackage

`default_nettype wire

// File: rtl/core/olpt_front.sv
// olpt_front: configuration registers, threshold classification and the classified queue
// depends on olpt_pkg
`default_nettype none

module olpt_front import olpt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  sample_t               sample,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cls_t                  head,
	output logic                  avail,
	input  logic                  take
);

	logic [CFG_DATA_W-1:0] thr_q [THR_REGS];
	logic [IDS_W-1:0]      ids_q;

	logic [CFG_DATA_W-1:0] thr_word;
	logic [VAL_W-1:0]      thr;
	logic [VAL_W+1:0]      val_x;
	logic [VAL_W+1:0]      thr_x2;
	logic [VAL_W+1:0]      thr_x3;
	logic [ID_W-1:0]       ids_arr [ID_SLOTS];
	logic                  ch_ok;
	cls_t                  cls;

	cls_t                  q_mem_q [Q_DEPTH];
	logic [Q_AW-1:0]       q_wr_q;
	logic [Q_AW-1:0]       q_rd_q;
	logic [Q_CW-1:0]       q_count_q;
	logic                  acc;

	assign cfg_ready = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < THR_REGS; k++) begin
				thr_q[k] <= '1;
			end
			ids_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_THR_CH01:   thr_q[0] <= cfg_data;
				REG_THR_CH23:   thr_q[1] <= cfg_data;
				REG_THR_CH45:   thr_q[2] <= cfg_data;
				REG_THR_CH67:   thr_q[3] <= cfg_data;
				REG_MODULE_IDS: ids_q <= cfg_data[IDS_W-1:0];
				default: ;
			endcase
		end
	end

	// per-channel module id slices
	always_comb begin
		for (int k = 0; k < ID_SLOTS; k++) begin
			ids_arr[k] = ids_q[ID_W*k +: ID_W];
		end
	end

	// threshold multiples compared exactly in 34 bits
	assign thr_word = thr_q[sample.channel[2:1]];
	assign thr      = sample.channel[0] ? thr_word[CFG_DATA_W-1:VAL_W] : thr_word[VAL_W-1:0];
	assign val_x    = {2'b00, sample.sample_value};
	assign thr_x2   = {1'b0, thr, 1'b0};
	assign thr_x3   = thr_x2 + {2'b00, thr};
	assign ch_ok    = ({1'b0, sample.channel} < (CH_FIELD_W+1)'(CHANNELS));

	// band classification
	always_comb begin
		cls              = '0;
		cls.channel      = sample.channel;
		cls.ch_ok        = ch_ok;
		cls.mit_id       = ids_arr[sample.channel];
		cls.new_window   = sample.new_window;
		cls.sample_value = sample.sample_value;
		cls.sample_time  = sample.sample_time;
		cls.window_index = sample.window_index;
		cls.band         = BAND_NONE;
		if (ch_ok && (sample.sample_value >= thr)) begin
			cls.hit = 1'b1;
			if (val_x >= thr_x3) begin
				cls.band = BAND_HIGH;
			end else if (val_x >= thr_x2) begin
				cls.band = BAND_MID;
			end else begin
				cls.band = BAND_LOW;
			end
		end
	end

	// classified queue
	assign full  = (q_count_q == Q_CW'(Q_DEPTH));
	assign avail = (q_count_q != '0);
	assign acc   = push && !full;
	assign head  = q_mem_q[q_rd_q];

	always_ff @(posedge clk) begin
		if (acc) begin
			q_mem_q[q_wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_wr_q    <= '0;
			q_rd_q    <= '0;
			q_count_q <= '0;
		end else begin
			if (acc) begin
				q_wr_q <= q_wr_q + 1'b1;
			end
			if (take) begin
				q_rd_q <= q_rd_q + 1'b1;
			end
			if (acc && !take) begin
				q_count_q <= q_count_q + 1'b1;
			end else if (!acc && take) begin
				q_count_q <= q_count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	// an accepted transaction with nothing taken grows the queue by one
	a_queue_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && !take) |=> (q_count_q == $past(q_count_q) + 1'b1))
		else $error("classified queue count did not grow");
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count_q <= Q_CW'(Q_DEPTH))
		else $error("classified queue overflow");
	a_take_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> avail)
		else $error("take from an empty classified queue");
`endif

endmodule

`default_nettype wire

// File: rtl/core/olpt_back.sv
// olpt_back: per-channel counters, peak store, mitigation mask and the result queue
// depends on olpt_pkg
`default_nettype none

module olpt_back import olpt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cls_t    head,
	input  logic    avail,
	output logic    take,
	output result_t result,
	output logic    empty,
	input  logic    pop
);

	logic [CNT_W-1:0]  low_q  [CHANNELS];
	logic [CNT_W-1:0]  mid_q  [CHANNELS];
	logic [CNT_W-1:0]  high_q [CHANNELS];
	logic [VAL_W-1:0]  pval_q [CHANNELS];
	logic [TIME_W-1:0] ptim_q [CHANNELS];
	logic [WIN_W-1:0]  pwin_q [CHANNELS];
	logic [MASK_W-1:0] mask_q;

	logic [CH_W-1:0]   idx;
	logic [CNT_W-1:0]  low_n;
	logic [CNT_W-1:0]  mid_n;
	logic [CNT_W-1:0]  high_n;
	logic              upd;
	logic [MASK_W-1:0] set_bit;
	logic [MASK_W-1:0] mask_n;
	logic              exec;
	logic              pop_ok;
	result_t           res;

	result_t           oq_mem_q [Q_DEPTH];
	logic [Q_AW-1:0]   oq_wr_q;
	logic [Q_AW-1:0]   oq_rd_q;
	logic [Q_CW-1:0]   oq_count_q;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		sat_inc = (&c) ? c : c + 1'b1;
	endfunction

	// run one classified transaction whenever the result queue has room or is being popped
	assign pop_ok = pop && !empty;
	assign exec   = avail && ((oq_count_q != Q_CW'(Q_DEPTH)) || pop_ok);
	assign take   = exec;

	assign idx     = head.channel[CH_W-1:0];
	assign set_bit = head.hit ? (MASK_W'(1) << head.mit_id) : '0;
	assign mask_n  = (head.new_window ? '0 : mask_q) | set_bit;
	assign upd     = head.sample_value >= pval_q[idx];

	// next counter values
	always_comb begin
		low_n  = low_q[idx];
		mid_n  = mid_q[idx];
		high_n = high_q[idx];
		case (head.band)
			BAND_LOW:  low_n  = sat_inc(low_q[idx]);
			BAND_MID:  mid_n  = sat_inc(mid_q[idx]);
			BAND_HIGH: high_n = sat_inc(high_q[idx]);
			default: ;
		endcase
	end

	// result assembly
	always_comb begin
		res                 = '0;
		res.out_channel     = head.channel;
		res.mitigation_mask = mask_n;
		if (head.ch_ok) begin
			res.band         = head.band;
			res.count_low    = low_n;
			res.count_mid    = mid_n;
			res.count_high   = high_n;
			res.peak_value   = upd ? head.sample_value : pval_q[idx];
			res.peak_time    = upd ? head.sample_time : ptim_q[idx];
			res.peak_window  = upd ? head.window_index : pwin_q[idx];
			res.peak_updated = upd;
		end
	end

	// per-channel state and mask
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < CHANNELS; k++) begin
				low_q[k]  <= '0;
				mid_q[k]  <= '0;
				high_q[k] <= '0;
				pval_q[k] <= '0;
				ptim_q[k] <= '0;
				pwin_q[k] <= '0;
			end
			mask_q <= '0;
		end else if (exec) begin
			mask_q <= mask_n;
			if (head.ch_ok) begin
				low_q[idx]  <= low_n;
				mid_q[idx]  <= mid_n;
				high_q[idx] <= high_n;
				if (upd) begin
					pval_q[idx] <= head.sample_value;
					ptim_q[idx] <= head.sample_time;
					pwin_q[idx] <= head.window_index;
				end
			end
		end
	end

	// result queue
	assign empty  = (oq_count_q == '0);
	assign result = oq_mem_q[oq_rd_q];

	always_ff @(posedge clk) begin
		if (exec) begin
			oq_mem_q[oq_wr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q    <= '0;
			oq_rd_q    <= '0;
			oq_count_q <= '0;
		end else begin
			if (exec) begin
				oq_wr_q <= oq_wr_q + 1'b1;
			end
			if (pop_ok) begin
				oq_rd_q <= oq_rd_q + 1'b1;
			end
			if (exec && !pop_ok) begin
				oq_count_q <= oq_count_q + 1'b1;
			end else if (!exec && pop_ok) begin
				oq_count_q <= oq_count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_oq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		oq_count_q <= Q_CW'(Q_DEPTH))
		else $error("result queue overflow");
	a_mask_set: assert property (@(posedge clk) disable iff (!arst_n)
		(exec && head.hit) |=> ((mask_q & $past(set_bit)) != '0))
		else $error("module bit missing from mask after threshold hit");
	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		(exec && !pop_ok) |=> !empty)
		else $error("result not presented after execution");
`endif

endmodule

`default_nettype wire

// File: rtl/core/overcurrent_level_peak_tracker_top.sv
// A sample is queued in the front, then its result in the result queue (empty low).
// Throughput: one transaction per cycle while the result queue has room or is popped;
// each one updates a channel's counters, peak and mask; 2-entry queues sit either side.
// Reset: counters, peaks and mask clear at once; thresholds go to all ones and
// module ids to zero; no clearing pass, the block takes samples right after reset.
// Top level: joins olpt_front and olpt_back, depends on olpt_pkg
`default_nettype none

module overcurrent_level_peak_tracker_top import olpt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  sample_t               sample,
	output logic                  empty,
	input  logic                  pop,
	output result_t               result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cls_t head;
	logic cls_avail;
	logic cls_take;

	// front: classification and classified queue
	olpt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.sample    (sample),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.head      (head),
		.avail     (cls_avail),
		.take      (cls_take)
	);

	// back: state update and result queue
	olpt_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.avail  (cls_avail),
		.take   (cls_take),
		.result (result),
		.empty  (empty),
		.pop    (pop)
	);

endmodule

`default_nettype wire

// File: tb/testbench.sv
// testbench: self-checking bench for overcurrent_level_peak_tracker_top, band, mask and peak checks
// drives samples and register writes, predicts each result and compares it field by field
// depends on olpt_pkg and the tracker top level
`timescale 1ns / 1ps

module testbench;
	import olpt_pkg::*;

	// receiver stall patterns
	localparam int RX_STEADY  = 0;
	localparam int RX_RANDOM  = 1;
	localparam int RX_PATTERN = 2;
	localparam int RX_SPARSE  = 3;

	localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = REG_MODULE_IDS + 1'b1;
	localparam int CH_CODES       = 1 << CH_FIELD_W;
	localparam int PHASES         = 6;
	localparam int PHASE_SAMPLES  = 222;
	localparam int DRAIN_CYCLES   = 8;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  push = 1'b0;
	logic                  full;
	sample_t               sample = '0;
	logic                  empty;
	logic                  pop = 1'b0;
	result_t               result;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// tracker state as the bench sees it
	logic [CFG_DATA_W-1:0] thr_pair [THR_REGS];
	logic [IDS_W-1:0]      mit_ids_reg;
	logic [CNT_W-1:0]      low_cnt  [CHANNELS];
	logic [CNT_W-1:0]      mid_cnt  [CHANNELS];
	logic [CNT_W-1:0]      high_cnt [CHANNELS];
	logic [VAL_W-1:0]      peak_val [CHANNELS];
	logic [TIME_W-1:0]     peak_tim [CHANNELS];
	logic [WIN_W-1:0]      peak_win [CHANNELS];
	logic [MASK_W-1:0]     mod_mask;

	result_t pending_results [$];

	int errors = 0;
	int samples_sent = 0;
	int results_seen = 0;
	int cfg_writes = 0;
	int full_stalls = 0;
	int peak_updates = 0;
	int band_tally [4] = '{default: 0};

	// sender burst control and receiver hold-off request
	int burst_left = 0;
	bit tx_gaps_on = 1'b1;
	bit hold_req = 1'b0;
	int hold_len = 0;

	overcurrent_level_peak_tracker_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.sample    (sample),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic logic [VAL_W-1:0] chan_threshold(input logic [CH_FIELD_W-1:0] ch);
		logic [CFG_DATA_W-1:0] pair;
		pair = thr_pair[ch[2:1]];
		return ch[0] ? pair[63:32] : pair[31:0];
	endfunction

	function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
		return (c == '1) ? c : c + 1'b1;
	endfunction

	// band, mask, counter and peak update for one sample
	function automatic result_t track_sample(input sample_t s);
		result_t r;
		logic [63:0] thr;
		logic [63:0] val;
		logic [ID_W-1:0] id;
		int ch;
		r = '0;
		ch = s.channel;
		r.out_channel = s.channel;
		if (s.new_window)
			mod_mask = '0;
		if (ch < CHANNELS) begin
			thr = {32'b0, chan_threshold(s.channel)};
			val = {32'b0, s.sample_value};
			if (val >= thr) begin
				id = mit_ids_reg[ID_W*ch +: ID_W];
				mod_mask[id] = 1'b1;
				// multiples formed in 64 bits so they never wrap
				if (val >= thr * 3) begin
					r.band = BAND_HIGH;
					high_cnt[ch] = bump(high_cnt[ch]);
				end else if (val >= thr * 2) begin
					r.band = BAND_MID;
					mid_cnt[ch] = bump(mid_cnt[ch]);
				end else begin
					r.band = BAND_LOW;
					low_cnt[ch] = bump(low_cnt[ch]);
				end
			end
			// equal value still takes over the peak
			if (s.sample_value >= peak_val[ch]) begin
				peak_val[ch] = s.sample_value;
				peak_tim[ch] = s.sample_time;
				peak_win[ch] = s.window_index;
				r.peak_updated = 1'b1;
				peak_updates++;
			end
			r.count_low   = low_cnt[ch];
			r.count_mid   = mid_cnt[ch];
			r.count_high  = high_cnt[ch];
			r.peak_value  = peak_val[ch];
			r.peak_time   = peak_tim[ch];
			r.peak_window = peak_win[ch];
		end
		r.mitigation_mask = mod_mask;
		band_tally[r.band]++;
		return r;
	endfunction

	function automatic sample_t make_sample(input int ch, input logic [VAL_W-1:0] val,
			input bit nw);
		sample_t s;
		logic [63:0] t;
		t = {$urandom, $urandom};
		s.channel      = ch[CH_FIELD_W-1:0];
		s.sample_value = val;
		s.sample_time  = t[TIME_W-1:0];
		s.window_index = WIN_W'($urandom_range(0, 16'hFFFF));
		s.new_window   = nw;
		return s;
	endfunction

	// values clustered around the threshold multiples of the chosen channel, mixed with extremes and random values
	function automatic sample_t random_sample();
		int ch;
		logic [63:0] t;
		logic [63:0] v;
		ch = $urandom_range(0, CH_CODES - 1);
		t = {32'b0, chan_threshold(ch[CH_FIELD_W-1:0])};
		case ($urandom_range(0, 7))
			0: v = $urandom;
			1: v = t + $urandom_range(0, 2) - 1;
			2: v = 2 * t + $urandom_range(0, 2) - 1;
			3: v = 3 * t + $urandom_range(0, 2) - 1;
			4: v = 0;
			5: v = 64'hFFFF_FFFF;
			6: v = $urandom_range(0, 2000);
			default: v = (t == 0) ? 64'd0 : $urandom % t;
		endcase
		if (v > 64'hFFFF_FFFF)
			v = 64'hFFFF_FFFF;
		return make_sample(ch, v[31:0], $urandom_range(0, 9) == 0);
	endfunction

	function automatic logic [VAL_W-1:0] rand_threshold();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return $urandom_range(1, 1000);
			3: return $urandom;
			4: return $urandom_range(32'h4000_0000, 32'h5555_5555);
			default: return $urandom_range(32'h5555_5556, 32'hFFFF_FFFE);
		endcase
	endfunction

	// one sample transaction, with a random gap at the start of each burst when gaps are on
	task automatic offer_sample(input sample_t s);
		int gap;
		if (tx_gaps_on && burst_left == 0) begin
			gap = $urandom_range(1, 6);
			repeat (gap) begin
				@(negedge clk);
				push <= 1'b0;
			end
			burst_left = $urandom_range(1, 12);
		end
		if (burst_left > 0)
			burst_left--;
		@(negedge clk);
		push   <= 1'b1;
		sample <= s;
		@(posedge clk);
		while (full) begin
			full_stalls++;
			@(posedge clk);
		end
		pending_results.push_back(track_sample(s));
		samples_sent++;
	endtask

	// stop offering and wait until every outstanding result has been popped
	task automatic drain();
		@(negedge clk);
		push <= 1'b0;
		burst_left = 0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx < THR_REGS)
			thr_pair[idx[1:0]] = data;
		else if (idx == REG_MODULE_IDS)
			mit_ids_reg = data[IDS_W-1:0];
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
			errors++;
		end
	endtask

	// compare each popped result against the oldest prediction
	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && pop && !empty) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$error("result transaction with nothing outstanding, channel %0d",
					result.out_channel);
				errors++;
			end else begin
				want = pending_results.pop_front();
				check_field("out_channel", want.out_channel, result.out_channel);
				check_field("band", want.band, result.band);
				check_field("mitigation_mask", want.mitigation_mask, result.mitigation_mask);
				check_field("count_low", want.count_low, result.count_low);
				check_field("count_mid", want.count_mid, result.count_mid);
				check_field("count_high", want.count_high, result.count_high);
				check_field("peak_value", want.peak_value, result.peak_value);
				check_field("peak_time", want.peak_time, result.peak_time);
				check_field("peak_window", want.peak_window, result.peak_window);
				check_field("peak_updated", want.peak_updated, result.peak_updated);
			end
		end
	end

	// receiver: switches between stall patterns, honours long hold-off requests
	initial begin : receiver
		int mode;
		int mode_left;
		int hold_left;
		int tick;
		mode = RX_STEADY;
		mode_left = 0;
		hold_left = 0;
		tick = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = hold_len;
				hold_req = 1'b0;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(RX_STEADY, RX_SPARSE);
				mode_left = $urandom_range(20, 200);
			end
			mode_left--;
			tick++;
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				case (mode)
					RX_STEADY:  pop <= 1'b1;
					RX_RANDOM:  pop <= ($urandom_range(0, 1) == 1);
					RX_PATTERN: pop <= (tick % 5) < 3;
					default:    pop <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// reset values: thresholds all ones, ids zero
	task automatic test_defaults_after_reset();
		offer_sample(make_sample(0, '0, 1'b0));
		offer_sample(make_sample(1, '1, 1'b0));
		offer_sample({3'd7, 32'hFFFF_FFFF, {TIME_W{1'b1}}, 16'hFFFF, 1'b0});
	endtask

	// exact threshold multiples, including ones that overflow 32 bits
	task automatic test_band_edges();
		drain();
		write_reg(REG_THR_CH01, {32'h8000_0000, 32'd100});
		write_reg(REG_THR_CH23, {32'h0000_0000, 32'h6000_0000});
		write_reg(REG_MODULE_IDS,
			{5'd12, 5'd24, 5'd2, 5'd9, 5'd5, 5'd17, 5'd0, 5'd31});
		// unused indices must leave everything alone
		for (int i = REG_FIRST_UNUSED; i < (1 << CFG_IDX_W); i++)
			write_reg(CFG_IDX_W'(i), '1);
		offer_sample(make_sample(0, 32'd99, 1'b0));
		offer_sample(make_sample(0, 32'd100, 1'b0));
		offer_sample(make_sample(0, 32'd199, 1'b0));
		offer_sample(make_sample(0, 32'd200, 1'b0));
		offer_sample(make_sample(0, 32'd299, 1'b0));
		offer_sample(make_sample(0, 32'd300, 1'b0));
		offer_sample(make_sample(1, 32'hFFFF_FFFF, 1'b0));
		offer_sample(make_sample(2, 32'hFFFF_FFFF, 1'b0));
		offer_sample(make_sample(3, 32'd0, 1'b0));
	endtask

	// equal value replaces the peak, smaller one does not
	task automatic test_peak_tracking();
		offer_sample(make_sample(4, 32'd500, 1'b0));
		offer_sample(make_sample(4, 32'd500, 1'b0));
		offer_sample(make_sample(4, 32'd499, 1'b0));
	endtask

	// new window clears the mask before the sample's own bit goes in
	task automatic test_mask_windows();
		offer_sample(make_sample(0, 32'd100, 1'b1));
		offer_sample(make_sample(5, 32'd0, 1'b1));
		offer_sample(make_sample(3, 32'd7, 1'b0));
	endtask

	// receiver holds off while the sender keeps pushing, then sender waits for empty
	task automatic test_backpressure();
		drain();
		tx_gaps_on = 1'b0;
		hold_len = 60;
		hold_req = 1'b1;
		repeat (24)
			offer_sample(random_sample());
		drain();
		tx_gaps_on = 1'b1;
	endtask

	// random traffic under several register settings, extremes first
	task automatic test_random_phases();
		for (int p = 0; p < PHASES; p++) begin
			drain();
			case (p)
				0: begin
					for (int r = 0; r < THR_REGS; r++)
						write_reg(CFG_IDX_W'(r), '0);
					write_reg(REG_MODULE_IDS, '1);
				end
				1: begin
					for (int r = 0; r < THR_REGS; r++)
						write_reg(CFG_IDX_W'(r), '1);
					write_reg(REG_MODULE_IDS, '0);
				end
				default: begin
					for (int r = 0; r < THR_REGS; r++)
						write_reg(CFG_IDX_W'(r), {rand_threshold(), rand_threshold()});
					write_reg(REG_MODULE_IDS, {$urandom, $urandom});
					write_reg(CFG_IDX_W'($urandom_range(REG_FIRST_UNUSED,
						(1 << CFG_IDX_W) - 1)), {$urandom, $urandom});
				end
			endcase
			for (int n = 0; n < PHASE_SAMPLES; n++) begin
				if (n % 50 == 0)
					tx_gaps_on = ($urandom_range(0, 1) == 1);
				offer_sample(random_sample());
			end
		end
		drain();
	endtask

	initial begin
		// state after reset
		for (int r = 0; r < THR_REGS; r++)
			thr_pair[r] = '1;
		mit_ids_reg = '0;
		for (int c = 0; c < CHANNELS; c++) begin
			low_cnt[c]  = '0;
			mid_cnt[c]  = '0;
			high_cnt[c] = '0;
			peak_val[c] = '0;
			peak_tim[c] = '0;
			peak_win[c] = '0;
		end
		mod_mask = '0;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_defaults_after_reset();
		test_band_edges();
		test_peak_tracking();
		test_mask_windows();
		test_backpressure();
		test_random_phases();

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("run: %0d samples, %0d results checked, %0d register writes, %0d full stalls",
			samples_sent, results_seen, cfg_writes, full_stalls);
		$display("bands none/low/mid/high %0d/%0d/%0d/%0d, peak replaced %0d times",
			band_tally[0], band_tally[1], band_tally[2], band_tally[3], peak_updates);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
